// ===== src/irpst_pkg.sv =====
package irpst_pkg;

	// field widths
	localparam int unsigned TIME_W = 32;
	localparam int unsigned DUR_W  = 24;
	localparam int unsigned BIT_W  = 16;

	// duration saturation
	localparam int unsigned       USEC_PER_SEC = 1000000;
	localparam int unsigned       SAT_SECONDS  = 15;
	localparam logic [TIME_W-1:0] SAT_LIMIT    = TIME_W'((SAT_SECONDS + 1) * USEC_PER_SEC);
	localparam logic [DUR_W-1:0]  DUR_MAX      = 24'hFFFFFF;

	// bit time after reset
	localparam logic [BIT_W-1:0] BIT_TIME_RESET = 16'd208;

	// event commands
	typedef enum logic {
		CMD_SAMPLE  = 1'b0,
		CMD_TIMEOUT = 1'b1
	} irpst_cmd_t;

	// one duration word
	typedef struct packed {
		logic             is_pulse;
		logic [DUR_W-1:0] duration_us;
		logic             last;
	} irpst_word_t;

	// modular time difference, saturated at sixteen seconds
	function automatic logic [DUR_W-1:0] elapsed(input logic [TIME_W-1:0] from_t,
		input logic [TIME_W-1:0] to_t);
		logic [TIME_W-1:0] diff;
		diff = to_t - from_t;
		return (diff >= SAT_LIMIT) ? DUR_MAX : diff[DUR_W-1:0];
	endfunction

endpackage

// ===== src/irpst_evt_if.sv =====
interface irpst_evt_if
	import irpst_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [TIME_W-1:0] time_us;

	modport source (output valid, output cmd, output time_us, input ready);
	modport sink (input valid, input cmd, input time_us, output ready);
endinterface

// ===== src/irpst_dur_if.sv =====
interface irpst_dur_if
	import irpst_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             is_pulse;
	logic [DUR_W-1:0] duration_us;
	logic             last;

	modport source (output valid, output is_pulse, output duration_us, output last,
		input ready);
	modport sink (input valid, input is_pulse, input duration_us, input last,
		output ready);
endinterface

// ===== src/ir_pulse_space_timing_capture.sv =====
// an event beat is registered in the input stage when accepted; its words are then written
//   into the output queue, and the first shows on dur as soon as it is stored; the second
//   word of a pair shows once the first has been taken
// throughput: one event per cycle; an event that closes a pulse and a space gives two
//   words, which the output queue absorbs; evt.ready drops while the queue is near full
// reset (arst_n low): no level running, start and sample times zero, bit time 208 us,
//   queue empty; no clearing pass
module ir_pulse_space_timing_capture
	import irpst_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [BIT_W-1:0]    cfg_wdata,
	irpst_evt_if.sink           evt,
	irpst_dur_if.source         dur
);

	// queue depth must be a power of two, at least four
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 2;

	// configuration and level state
	logic [BIT_W-1:0]  bit_time_q;
	logic              level_q;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] prev_q;

	// input stage
	logic              valid_s1;
	logic              cmd_s1;
	logic [TIME_W-1:0] time_s1;

	// output queue
	irpst_word_t       fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	logic              evt_acc;
	logic              dur_acc;
	logic              is_sample;
	logic              is_timeout;
	logic [BIT_W-2:0]  half;
	logic [DUR_W-1:0]  since_level;
	logic [DUR_W-1:0]  since_sample;
	logic [DUR_W-1:0]  pulse_d;
	logic [DUR_W-1:0]  pulse_w;
	logic              gap;
	logic              close_pulse;
	logic [DUR_W-1:0]  space_d;
	logic [DUR_W-1:0]  space_base;
	logic [DUR_W:0]    space_sum;
	logic [DUR_W-1:0]  space_w;
	irpst_word_t       word0;
	irpst_word_t       word1;
	logic [1:0]        n_push;
	logic [SUM_W-1:0]  need;

	// handshakes
	assign need    = SUM_W'(count_q) + (valid_s1 ? SUM_W'(2) : SUM_W'(0)) + SUM_W'(2);
	assign evt.ready = (need <= SUM_W'(FIFO_DEPTH));
	assign evt_acc = evt.valid && evt.ready;
	assign dur_acc = dur.valid && dur.ready;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= evt_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			cmd_s1  <= evt.cmd;
			time_s1 <= evt.time_us;
		end
	end

	// durations
	assign is_sample    = valid_s1 && (cmd_s1 == CMD_SAMPLE);
	assign is_timeout   = valid_s1 && (cmd_s1 == CMD_TIMEOUT);
	assign half         = bit_time_q[BIT_W-1:1];
	assign since_level  = elapsed(start_q, time_s1);
	assign since_sample = elapsed(prev_q, time_s1);
	assign pulse_d      = elapsed(start_q, prev_q);

	// pulse shortened by half a bit, floor of one
	assign pulse_w = (pulse_d > DUR_W'(half)) ? (pulse_d - DUR_W'(half)) : DUR_W'(1);

	// gap longer than two bit times closes a running pulse
	assign gap         = ({1'b0, since_sample} > {(DUR_W + 1 - BIT_W - 1)'(0), bit_time_q, 1'b0});
	assign close_pulse = is_sample && level_q && gap;

	// space ends one bit before the sample, then lengthened by half a bit
	assign space_d    = close_pulse ? since_sample : since_level;
	assign space_base = (space_d < DUR_W'(bit_time_q)) ? DUR_W'(0)
		: (space_d - DUR_W'(bit_time_q));
	assign space_sum  = {1'b0, space_base} + (DUR_W + 1)'(half);
	assign space_w    = space_sum[DUR_W] ? DUR_MAX : space_sum[DUR_W-1:0];

	// words caused by the registered event
	always_comb begin
		n_push = 2'd0;
		word0  = '{is_pulse: 1'b0, duration_us: space_w, last: 1'b1};
		word1  = '{is_pulse: 1'b0, duration_us: space_w, last: 1'b1};
		if (is_timeout) begin
			if (level_q) begin
				word0  = '{is_pulse: 1'b1, duration_us: pulse_w, last: 1'b1};
				n_push = 2'd1;
			end
		end else if (is_sample) begin
			if (close_pulse) begin
				word0  = '{is_pulse: 1'b1, duration_us: pulse_w, last: 1'b0};
				n_push = 2'd2;
			end else if (!level_q) begin
				n_push = 2'd1;
			end
		end
	end

	// bit time register and level tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q <= BIT_TIME_RESET;
			level_q    <= 1'b0;
			start_q    <= '0;
			prev_q     <= '0;
		end else begin
			if (cfg_we) begin
				bit_time_q <= cfg_wdata;
			end
			if (is_timeout && level_q) begin
				level_q <= 1'b0;
				start_q <= prev_q;
			end
			if (is_sample) begin
				prev_q <= time_s1;
				if (close_pulse || !level_q) begin
					level_q <= 1'b1;
					start_q <= time_s1 - TIME_W'(bit_time_q);
				end
			end
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (dur_acc) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(n_push) - (dur_acc ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= word0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= word1;
		end
	end

	// output beat from the queue head
	assign dur.valid       = (count_q != '0);
	assign dur.is_pulse    = fifo_q[rd_ptr_q].is_pulse;
	assign dur.duration_us = fifo_q[rd_ptr_q].duration_us;
	assign dur.last        = fifo_q[rd_ptr_q].last;

`ifndef ASSERT_OFF
	// queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("output queue overfilled");

	// accepting leaves room for two words of the event in flight
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		evt.ready |-> (SUM_W'(count_q) + (valid_s1 ? SUM_W'(2) : SUM_W'(0))
			<= SUM_W'(FIFO_DEPTH - 2)))
		else $error("input accepted without queue room");

	// two words only from a sample that closes a pulse
	a_two_words: assert property (@(posedge clk) disable iff (!arst_n)
		(n_push == 2'd2) |-> (is_sample && level_q))
		else $error("two words from an event that cannot close a pulse");

	// a timeout always ends with no pulse running
	a_timeout_level: assert property (@(posedge clk) disable iff (!arst_n)
		is_timeout |=> !level_q)
		else $error("pulse still running after timeout");

	// a sample always leaves a pulse running at its own time
	a_sample_level: assert property (@(posedge clk) disable iff (!arst_n)
		is_sample |=> (level_q && (prev_q == $past(time_s1))))
		else $error("sample did not start or keep a pulse");
`endif

endmodule

// ===== dv/irpst_checker.sv =====
`timescale 1ns / 100ps

module irpst_checker
	import irpst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [BIT_W-1:0] cfg_wdata,
	irpst_evt_if             evt,
	irpst_dur_if             dur,
	output int unsigned      mismatches,
	output int unsigned      outstanding
);

	localparam int unsigned PRINT_CAP = 100;

	// shadow of the capture state
	logic [BIT_W-1:0]  bit_time;
	logic              pulse_on;
	logic [TIME_W-1:0] level_start;
	logic [TIME_W-1:0] prev_sample;

	irpst_word_t expected_words[$];
	int unsigned fail_count = 0;
	int unsigned word_count = 0;

	assign mismatches  = fail_count;
	assign outstanding = word_count;

	// one line per mismatch, quiet after the cap
	task automatic note_mismatch(input string what);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, what);
	endtask

	// modular distance, pinned at sixteen seconds
	function automatic logic [TIME_W-1:0] span_us(input logic [TIME_W-1:0] from_us,
		input logic [TIME_W-1:0] to_us);
		logic [TIME_W-1:0] diff;
		diff = to_us - from_us;
		return (diff >= SAT_LIMIT) ? TIME_W'(DUR_MAX) : diff;
	endfunction

	// pulse trimmed by half a bit, never below one
	function automatic logic [DUR_W-1:0] pulse_len(input logic [TIME_W-1:0] d);
		logic [TIME_W-1:0] half;
		half = TIME_W'(bit_time >> 1);
		return (d > half) ? DUR_W'(d - half) : DUR_W'(1);
	endfunction

	// space ends one bit early, then grows by half a bit
	function automatic logic [DUR_W-1:0] space_len(input logic [TIME_W-1:0] d);
		logic [TIME_W-1:0] half;
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] sum;
		half = TIME_W'(bit_time >> 1);
		base = (d < TIME_W'(bit_time)) ? '0 : d - TIME_W'(bit_time);
		sum  = base + half;
		return (sum > TIME_W'(DUR_MAX)) ? DUR_MAX : sum[DUR_W-1:0];
	endfunction

	function automatic irpst_word_t word_of(input logic is_pulse, input logic [DUR_W-1:0] len);
		irpst_word_t w;
		w.is_pulse    = is_pulse;
		w.duration_us = len;
		w.last        = 1'b0;
		return w;
	endfunction

	// words caused by one event beat
	function automatic void predict_event(input irpst_cmd_t cmd, input logic [TIME_W-1:0] now_us);
		irpst_word_t       made[$];
		logic [TIME_W-1:0] since_level;
		logic [TIME_W-1:0] since_sample;
		if (cmd == CMD_TIMEOUT) begin
			if (pulse_on) begin
				made.push_back(word_of(1'b1, pulse_len(span_us(level_start, prev_sample))));
				pulse_on    = 1'b0;
				level_start = prev_sample;
			end
		end else begin
			since_level  = span_us(level_start, now_us);
			since_sample = span_us(prev_sample, now_us);
			// long silence ends the pulse at the previous sample
			if (since_sample > TIME_W'({bit_time, 1'b0}) && pulse_on) begin
				made.push_back(word_of(1'b1, pulse_len(span_us(level_start, prev_sample))));
				pulse_on    = 1'b0;
				level_start = prev_sample;
				since_level = since_sample;
			end
			// close the space, pulse taken to start one bit back
			if (!pulse_on) begin
				made.push_back(word_of(1'b0, space_len(since_level)));
				pulse_on    = 1'b1;
				level_start = now_us - TIME_W'(bit_time);
			end
			prev_sample = now_us;
		end
		if (made.size() != 0)
			made[made.size() - 1].last = 1'b1;
		foreach (made[i])
			expected_words.push_back(made[i]);
	endfunction

	task automatic check_word(input logic is_pulse, input logic [DUR_W-1:0] duration_us,
		input logic last);
		irpst_word_t want;
		if (expected_words.size() == 0) begin
			note_mismatch($sformatf("unexpected word pulse=%0b dur=%0d last=%0b",
				is_pulse, duration_us, last));
		end else begin
			want = expected_words.pop_front();
			if (is_pulse !== want.is_pulse)
				note_mismatch($sformatf("is_pulse %0b, want %0b", is_pulse, want.is_pulse));
			if (duration_us !== want.duration_us)
				note_mismatch($sformatf("duration_us %0d, want %0d (pulse=%0b)",
					duration_us, want.duration_us, want.is_pulse));
			if (last !== want.last)
				note_mismatch($sformatf("last %0b, want %0b", last, want.last));
		end
	endtask

	// watch config, event and duration beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time    = BIT_TIME_RESET;
			pulse_on    = 1'b0;
			level_start = '0;
			prev_sample = '0;
			expected_words.delete();
		end else begin
			if (cfg_we)
				bit_time = cfg_wdata;
			if (evt.valid && evt.ready)
				predict_event(irpst_cmd_t'(evt.cmd), evt.time_us);
			if (dur.valid && dur.ready)
				check_word(dur.is_pulse, dur.duration_us, dur.last);
		end
		word_count = expected_words.size();
	end

endmodule

// ===== dv/ir_pulse_space_timing_capture_tb.sv =====
`timescale 1ns / 100ps

module ir_pulse_space_timing_capture_tb;
	import irpst_pkg::*;

	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned ITEMS_PER_PHASE = 190;
	localparam int unsigned PHASES          = 8;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [BIT_W-1:0] cfg_wdata;

	irpst_evt_if evt();
	irpst_dur_if dur();

	int unsigned       mismatches;
	int unsigned       outstanding;
	int unsigned       src_idle_pct  = 0;
	int unsigned       snk_stall_pct = 0;
	logic              hold_off_req  = 1'b0;
	logic [TIME_W-1:0] stamp;
	int unsigned       bit_time_us;

	ir_pulse_space_timing_capture u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.evt       (evt),
		.dur       (dur)
	);

	irpst_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.evt         (evt),
		.dur         (dur),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// duration receiver, with one long hold-off on request
	initial begin
		dur.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				dur.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			dur.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// offer one event beat, wait for it to be taken
	task automatic send_event(input irpst_cmd_t cmd, input logic [TIME_W-1:0] at_us);
		while ($urandom_range(99) < src_idle_pct) begin
			evt.valid <= 1'b0;
			@(posedge clk);
		end
		evt.valid   <= 1'b1;
		evt.cmd     <= cmd;
		evt.time_us <= at_us;
		@(posedge clk);
		while (!evt.ready)
			@(posedge clk);
	endtask

	task automatic sample_step(input logic [TIME_W-1:0] delta);
		stamp = stamp + delta;
		send_event(CMD_SAMPLE, stamp);
	endtask

	// wait until every word is out and the pipeline is empty
	task automatic settle();
		evt.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_bit_time(input logic [BIT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		bit_time_us = 32'(value);
	endtask

	// random pulse trains, gaps, timeouts and wild jumps
	task automatic run_phase(input int unsigned n_items);
		int unsigned       pick;
		logic [TIME_W-1:0] delta;
		for (int unsigned i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_event(CMD_TIMEOUT, $urandom);
			end else begin
				if (pick < 55) begin
					delta = $urandom_range(2 * bit_time_us);
				end else if (pick < 62) begin
					case ($urandom_range(3))
						0: delta = bit_time_us - 1;
						1: delta = bit_time_us;
						2: delta = 2 * bit_time_us;
						default: delta = 2 * bit_time_us + 1;
					endcase
				end else if (pick < 85) begin
					delta = 2 * bit_time_us + 1 + $urandom_range(4 * bit_time_us + 2000);
				end else if (pick < 90) begin
					delta = $urandom_range(16_010_000, 15_990_000);
				end else begin
					delta = $urandom;
				end
				sample_step(delta);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		evt.valid     = 1'b0;
		evt.cmd       = CMD_SAMPLE;
		evt.time_us   = '0;
		stamp         = '0;
		bit_time_us   = 32'(BIT_TIME_RESET);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default bit time
		sample_step(0);
		sample_step(100);
		// gap of exactly two bits keeps the pulse, one more splits it
		sample_step(416);
		sample_step(417);
		send_event(CMD_TIMEOUT, $urandom);
		// timeout with nothing running
		send_event(CMD_TIMEOUT, 32'hFFFF_FFFF);
		// far jump, saturated space
		sample_step(32'hFFFF_FFF0 - stamp);
		sample_step(0);
		// saturated gap across the wrap
		sample_step(32'd16_000_000);
		send_event(CMD_TIMEOUT, '0);
		// space just under saturation
		sample_step(32'd15_999_999);
		// one tick backwards reads as a huge gap
		sample_step(32'hFFFF_FFFF);
		send_event(CMD_TIMEOUT, $urandom);

		// zero bit time: pulse word floors at one
		settle();
		write_bit_time(16'd0);
		sample_step(5);
		sample_step(0);
		send_event(CMD_TIMEOUT, $urandom);

		// bit time of one, half bit is zero
		settle();
		write_bit_time(16'd1);
		sample_step(3);
		sample_step(2);
		sample_step(3);
		send_event(CMD_TIMEOUT, $urandom);

		// largest bit time
		settle();
		write_bit_time(16'hFFFF);
		sample_step(131070);
		sample_step(131071);
		send_event(CMD_TIMEOUT, $urandom);

		// random phases over idling modes and bit times
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 4)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 82;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 82;
				end
				default: begin
					src_idle_pct  = 34;
					snk_stall_pct = 34;
				end
			endcase
			case (p)
				0: write_bit_time(BIT_TIME_RESET);
				1: write_bit_time(16'd2);
				2: write_bit_time(16'hFFFF);
				4: write_bit_time(16'd1);
				5: write_bit_time(16'd0);
				6: write_bit_time(BIT_W'($urandom_range(300, 2)));
				default: write_bit_time(BIT_W'($urandom_range(65535, 2)));
			endcase
			// fill the output queue until the input stalls
			if (p == 0)
				hold_off_req = 1'b1;
			run_phase(ITEMS_PER_PHASE);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
